// File: hw/rtl/sha1_pkg.sv
// Shared types and constants of the SHA-1 digest engine.
`default_nettype none
package sha1_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned BlkBytes = 64;
    localparam int unsigned PosW     = 6;
    localparam int unsigned LenW     = 61;
    localparam int unsigned RoundW   = 7;
    localparam int unsigned Rounds   = 80;

    localparam logic [WordW-1:0] H0_INIT = 32'h67452301;
    localparam logic [WordW-1:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [WordW-1:0] H2_INIT = 32'h98BADCFE;
    localparam logic [WordW-1:0] H3_INIT = 32'h10325476;
    localparam logic [WordW-1:0] H4_INIT = 32'hC3D2E1F0;
    localparam logic [WordW-1:0] K0 = 32'h5A827999;
    localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
    localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
    localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Byte sources for the buffer write port.
    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_PAD  = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } byte_src_t;

    typedef struct packed {
        logic      wr;        // write one byte at the current position
        byte_src_t src;
        logic      count;     // advance the message length
        logic      start;     // begin a block compression
        logic      reinit;    // return position, length and chaining value to their reset values
    } dp_cmd_t;

    typedef struct packed {
        logic            busy;      // compression in progress
        logic [PosW-1:0] pos;
    } dp_stat_t;

    function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int unsigned s);
        rotl = (v << s) | (v >> (WordW - s));
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sha1_hash_engine.sv
// Top level of the SHA-1 digest engine.
// Usage:
//   Message bytes enter on the s_axis channel, one item per byte: tdata holds
//   data_byte, tuser holds byte_present, tlast ends the message. An item with
//   no byte that is not last is dropped. On the last item the block pads the
//   message, appends the bit length and delivers the 160-bit digest as one
//   item on m_axis (word 0 in the lowest bits).
//   Each byte takes one cycle; every 64th byte starts a compression (64 buffer
//   reads, a drain step for the last read to land, 80 rounds and one final add),
//   set by the single round unit, during which input is held off. Padding writes
//   one byte a cycle up to the block end, paused while a compression runs, and
//   may need one extra compression. The digest is loaded into the output register
//   once the final compression ends and the register is free; m_axis shows it at once.
//   The engine reinitializes as soon as the digest is loaded and accepts the
//   next message while the digest waits. If the receiver still stalls when
//   that next message is done, the engine holds off input until the digest
//   is taken.
//   After reset the chaining value holds the standard initial words and the
//   buffer is empty; no clearing pass is needed.
`default_nettype none
module sha1_hash_engine (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // [7:0] data_byte
    input  wire logic          s_axis_tuser,   // [0] byte_present
    input  wire logic          s_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [159:0]       m_axis_tdata    // digest_word_0 .. digest_word_4
);
    import sha1_pkg::*;

    dp_cmd_t        cmd;
    dp_stat_t       stat;
    logic [159:0]   digest;
    logic           out_load;
    logic           vld_reg;
    logic [159:0]   dat_reg;

    sha1_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_tvalid    (s_axis_tvalid),
        .in_tready    (s_axis_tready),
        .byte_present (s_axis_tuser),
        .last         (s_axis_tlast),
        .stat         (stat),
        .cmd          (cmd),
        .out_load     (out_load),
        .out_free     (!vld_reg || m_axis_tready)
    );

    sha1_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (s_axis_tdata),
        .stat      (stat),
        .digest    (digest)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            dat_reg <= digest;
        end
    end

    assign m_axis_tvalid = vld_reg;
    assign m_axis_tdata  = dat_reg;
endmodule
`default_nettype wire

// File: hw/rtl/sha1_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module sha1_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/sha1_datapath.sv
// Datapath: block buffer, length counter, schedule window and round unit.
`default_nettype none
module sha1_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sha1_pkg::dp_cmd_t    cmd,
    input  wire logic [7:0]           data_byte,
    output sha1_pkg::dp_stat_t        stat,
    output logic [5*32-1:0]           digest
);
    import sha1_pkg::*;

    // Step index of the first round: 16 load steps and one drain step come first.
    localparam int unsigned RoundBase = 17;

    logic [PosW-1:0]  pos_reg, pos_next;
    logic [LenW-1:0]  len_reg, len_next;
    logic [WordW-1:0] h_reg [5];
    logic [WordW-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [WordW-1:0] w_reg [16];
    logic             busy_reg;
    logic [RoundW-1:0] rnd_reg;   // 0..15 load, 16 drain, 17..96 rounds, 97 final add
    logic [1:0]       sub_reg;    // byte within the word being loaded
    logic             rd_ok_reg;
    logic [5:0]       ram_addr;
    logic [7:0]       wbyte, rbyte;
    logic [PosW-1:0]  rd_addr;
    logic [WordW-1:0] wt, f, k, tmp, wnew;
    logic [RoundW-1:0] t;
    logic [63:0]      bits;

    assign bits = {len_reg, 3'b000};

    always_comb
    begin
        unique case (cmd.src)
            SRC_DATA: wbyte = data_byte;
            SRC_PAD:  wbyte = PAD_BYTE;
            SRC_ZERO: wbyte = 8'h00;
            SRC_LEN:  wbyte = bits[8*(7 - pos_reg[2:0]) +: 8];
            default:  wbyte = 8'h00;
        endcase
    end

    // Load phase reads bytes 0..63 in order; rnd_reg[3:0] and sub_reg form the address.
    assign rd_addr  = {rnd_reg[3:0], sub_reg};
    assign ram_addr = busy_reg ? rd_addr : pos_reg;

    sha1_ram #(.WIDTH(8), .DEPTH(BlkBytes)) u_buf (
        .clk   (clk),
        .we    (cmd.wr && !busy_reg),
        .addr  (ram_addr),
        .wdata (wbyte),
        .rdata (rbyte)
    );

    assign pos_next = pos_reg + PosW'(1);
    assign len_next = len_reg + LenW'(1);

    // Round index once the 16 words are in.
    assign t    = rnd_reg - RoundW'(RoundBase);
    assign wnew = rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
    assign wt   = (t < RoundW'(16)) ? w_reg[t[3:0]] : wnew;

    always_comb
    begin
        if (t < RoundW'(20))
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = K0;
        end
        else if (t < RoundW'(40))
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K1;
        end
        else if (t < RoundW'(60))
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = K2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K3;
        end
    end

    assign tmp = rotl(a_reg, 5) + f + e_reg + k + wt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            len_reg   <= '0;
            busy_reg  <= 1'b0;
            rnd_reg   <= '0;
            sub_reg   <= '0;
            rd_ok_reg <= 1'b0;
            h_reg[0]  <= H0_INIT;
            h_reg[1]  <= H1_INIT;
            h_reg[2]  <= H2_INIT;
            h_reg[3]  <= H3_INIT;
            h_reg[4]  <= H4_INIT;
        end
        else if (cmd.reinit)
        begin
            pos_reg  <= '0;
            len_reg  <= '0;
            h_reg[0] <= H0_INIT;
            h_reg[1] <= H1_INIT;
            h_reg[2] <= H2_INIT;
            h_reg[3] <= H3_INIT;
            h_reg[4] <= H4_INIT;
        end
        else if (!busy_reg)
        begin
            if (cmd.count)
            begin
                len_reg <= len_next;
            end
            if (cmd.wr)
            begin
                pos_reg <= pos_next;
            end
            if (cmd.start)
            begin
                busy_reg  <= 1'b1;
                rnd_reg   <= '0;
                sub_reg   <= '0;
                rd_ok_reg <= 1'b0;
            end
        end
        else if (rnd_reg < RoundW'(16))
        begin
            // One read issued per cycle; the RAM registers its data, which shows in the next cycle.
            rd_ok_reg <= 1'b1;
            {rnd_reg, sub_reg} <= {rnd_reg, sub_reg} + 9'd1;
        end
        else if (rnd_reg < RoundW'(RoundBase))
        begin
            // The last byte read reaches the window in this cycle.
            rd_ok_reg <= 1'b0;
            rnd_reg   <= RoundW'(RoundBase);
        end
        else if (rnd_reg < RoundW'(RoundBase + Rounds))
        begin
            rnd_reg <= rnd_reg + RoundW'(1);
        end
        else
        begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
            busy_reg <= 1'b0;
        end
    end

    // Payload: schedule window and working variables.
    always_ff @(posedge clk)
    begin
        if (busy_reg && rnd_reg < RoundW'(RoundBase))
        begin
            // The window works as one 512-bit shift register, byte 0 ends up on top.
            if (rd_ok_reg)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= {w_reg[i][23:0], w_reg[i+1][31:24]};
                end
                w_reg[15] <= {w_reg[15][23:0], rbyte};
            end
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (busy_reg && rnd_reg < RoundW'(RoundBase + Rounds))
        begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= rotl(b_reg, 30);
            d_reg <= c_reg;
            e_reg <= d_reg;
            if (t >= RoundW'(16))
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[15] <= wnew;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.pos  = pos_reg;
    assign digest    = {h_reg[4], h_reg[3], h_reg[2], h_reg[1], h_reg[0]};
endmodule
`default_nettype wire

// File: hw/rtl/sha1_ctrl.sv
// Controller: sequences byte writes, padding and compressions.
`default_nettype none
module sha1_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_tvalid,
    output logic                    in_tready,
    input  wire logic               byte_present,
    input  wire logic               last,
    input  wire sha1_pkg::dp_stat_t stat,
    output sha1_pkg::dp_cmd_t       cmd,
    output logic                    out_load,
    input  wire logic               out_free
);
    import sha1_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WAIT  = 6'b000010,
        S_PAD   = 6'b000100,
        S_ZERO  = 6'b001000,
        S_LEN   = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '{wr: 1'b0, src: SRC_DATA, count: 1'b0, start: 1'b0, reinit: 1'b0};
        in_tready  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_tready = !stat.busy;
                if (in_tvalid && !stat.busy)
                begin
                    if (byte_present)
                    begin
                        cmd.wr    = 1'b1;
                        cmd.count = 1'b1;
                        cmd.start = (stat.pos == PosW'(BlkBytes - 1));
                        state_next = last ? S_WAIT : S_IDLE;
                    end
                    else if (last)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_WAIT:
            begin
                if (!stat.busy)
                begin
                    state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                cmd.wr  = 1'b1;
                cmd.src = SRC_PAD;
                if (stat.pos == PosW'(BlkBytes - 1))
                begin
                    cmd.start  = 1'b1;
                    state_next = S_ZERO;
                end
                else if (stat.pos == PosW'(BlkBytes - 9))
                begin
                    // The terminator fills the last byte before the length field.
                    state_next = S_LEN;
                end
                else
                begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (!stat.busy)
                begin
                    cmd.wr  = 1'b1;
                    cmd.src = SRC_ZERO;
                    if (stat.pos == PosW'(BlkBytes - 9))
                    begin
                        state_next = S_LEN;
                    end
                    else if (stat.pos == PosW'(BlkBytes - 1))
                    begin
                        cmd.start = 1'b1;
                    end
                end
            end
            S_LEN:
            begin
                cmd.wr  = 1'b1;
                cmd.src = SRC_LEN;
                if (stat.pos == PosW'(BlkBytes - 1))
                begin
                    cmd.start  = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!stat.busy && out_free)
                begin
                    out_load   = 1'b1;
                    cmd.reinit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("controller state not one-hot");
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> !in_tready)
        else $error("input taken during compression");
    a_len_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEN && stat.pos == PosW'(BlkBytes - 1)) |=> state_reg == S_FIN)
        else $error("length bytes not followed by final block");
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench of the SHA-1 digest engine on its byte stream interface.
`timescale 1ns / 100ps
module tb_top;
    import sha1_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;    // [7:0] data_byte
    logic         s_axis_tuser;    // [0] byte_present
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;    // digest_word_0 .. digest_word_4

    sha1_hash_engine uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Predictor state.
    logic [7:0]       msg_block [64];
    int unsigned      fill_count;
    logic [LenW-1:0]  byte_total;
    logic [WordW-1:0] chain [5];

    logic [159:0] digest_queue [$];
    int           error_count;
    int           hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [31:0] rol32(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic sha_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d); k = K0;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d; k = K1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d); k = K2;
            end
            else
            begin
                f = b ^ c ^ d; k = K3;
            end
            t = rol32(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol32(b, 30); b = a; a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endtask

    task automatic hash_restart();
        fill_count = 0;
        byte_total = '0;
        chain[0] = H0_INIT; chain[1] = H1_INIT; chain[2] = H2_INIT;
        chain[3] = H3_INIT; chain[4] = H4_INIT;
    endtask

    task automatic absorb_byte(logic [7:0] v);
        msg_block[fill_count] = v;
        fill_count++;
        if (fill_count == 64)
        begin
            sha_compress();
            fill_count = 0;
        end
    endtask

    task automatic predict_item(logic [7:0] data, logic present, logic fin);
        logic [63:0] bit_len;
        if (present)
        begin
            byte_total = byte_total + 1'b1;
            absorb_byte(data);
        end
        if (fin)
        begin
            bit_len = {byte_total, 3'b000};
            absorb_byte(PAD_BYTE);
            for (int i = fill_count; i < 64; i++)
                msg_block[i] = 8'h00;
            if (64 - fill_count < 8)
            begin
                sha_compress();
                for (int i = 0; i < 64; i++)
                    msg_block[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
                msg_block[63-i] = bit_len[8*i +: 8];
            sha_compress();
            digest_queue.push_back({chain[4], chain[3], chain[2], chain[1], chain[0]});
            hash_restart();
        end
    endtask

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Idles the input for a random number of cycles; valid drops only for a real gap.
    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Sends one item and updates the prediction when it is accepted.
    task automatic send_item(logic [7:0] data, logic present, logic fin, bit gaps = 1);
        if (gaps)
            random_gap();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= present;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_item(data, present, fin);
        @(negedge clk);
    endtask

    task automatic send_message(int len, int mode = 0);
        for (int i = 0; i < len; i++)
        begin
            logic [7:0] v;
            v = (mode == 1) ? 8'hFF : (mode == 2) ? 8'h00 : 8'($urandom);
            if (i < len - 1 && $urandom_range(0, 15) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(v, 1'b1, (i == len - 1) && mode != 3);
        end
        if (len == 0 || mode == 3)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (digest_queue.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    // Checks each digest against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_queue.size() == 0)
                report_mismatch("digest with none expected");
            else
            begin
                logic [159:0] want;
                want = digest_queue.pop_front();
                for (int i = 0; i < 5; i++)
                    if (m_axis_tdata[32*i +: 32] !== want[32*i +: 32])
                        report_mismatch($sformatf("digest_word_%0d got %h want %h", i,
                            m_axis_tdata[32*i +: 32], want[32*i +: 32]));
            end
        end
    end

    // Receiver stalls; one long hold-off is started by the stall test.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles--;
        end
        else if ($urandom_range(0, 24) == 0)
            m_axis_tready <= 1'b0;
        else if (!m_axis_tready && $urandom_range(0, 3) != 0)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    task automatic test_directed();
        send_message(0);
        send_message(1, 2);
        send_message(1, 1);
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64, 1);
        send_message(65);
        send_message(20, 3);
        send_item(8'hA5, 1'b0, 1'b0);
        send_message(3);
        wait_drained();
    endtask

    task automatic test_receiver_stall();
        hold_cycles = 3000;
        for (int m = 0; m < 6; m++)
            send_message($urandom_range(0, 10), 0);
        wait_drained();
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 650)
        begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 140) : $urandom_range(0, 20);
            send_message(len, $urandom_range(0, 7) == 0 ? 3 : 0);
            sent += len + 1;
            if ($urandom_range(0, 29) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        error_count = 0;
        hold_cycles = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        hash_restart();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_receiver_stall();
        test_random();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
